/* rtl/lcg48_pkg.sv */
// Shared types and constants of the 48-bit linear congruential generator.
`default_nettype none

package lcg48_pkg;

    localparam logic [47:0] LCG_MULT = 48'h0005_DEEC_E66D;
    localparam logic [47:0] LCG_ADD  = 48'h0000_0000_000B;
    localparam logic [47:0] LCG_SEED_RESET = LCG_MULT;

    typedef enum logic [2:0] {
        OP_RESEED  = 3'd0,
        OP_BITS    = 3'd1,
        OP_INT     = 3'd2,
        OP_BOUNDED = 3'd3,
        OP_LONG    = 3'd4,
        OP_BOOL    = 3'd5,
        OP_FLOAT   = 3'd6,
        OP_DOUBLE  = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP_GO,
        S_STEP_WAIT,
        S_MOD_WAIT,
        S_POW2,
        S_DONE
    } t_state;

    // Status that each multi-cycle unit reports back to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

`default_nettype wire

/* rtl/lcg48_step.sv */
// One generator step, s * multiplier + increment mod 2^48, over three 16-bit slices.
`default_nettype none

module lcg48_step
    import lcg48_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [47:0] i_state,
    output t_unit_stat       o_stat,
    output logic [47:0]      o_next
);

    logic [47:0] r_src;
    logic [47:0] r_acc;
    logic [1:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [15:0] slice;
    logic [50:0] prod;
    logic [47:0] term;

    always_comb begin
        unique case (r_cnt)
            2'd0:    slice = r_src[15:0];
            2'd1:    slice = r_src[31:16];
            default: slice = r_src[47:32];
        endcase
        prod = {35'b0, slice} * {16'b0, LCG_MULT[34:0]};
        unique case (r_cnt)
            2'd0:    term = prod[47:0];
            2'd1:    term = {prod[31:0], 16'b0};
            default: term = {prod[15:0], 32'b0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_done <= r_busy && (r_cnt == 2'd2);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 2'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd2) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // The increment is folded in as the starting value of the sum.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_src <= i_state;
            r_acc <= LCG_ADD;
        end else if (r_busy) begin
            r_acc <= r_acc + term;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_next      = r_acc;

endmodule

`default_nettype wire

/* rtl/lcg48_mod.sv */
// Restoring remainder unit for 31-bit operands, one quotient bit per cycle.
`default_nettype none

module lcg48_mod
    import lcg48_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [30:0] i_dividend,
    input  wire logic [30:0] i_divisor,
    output t_unit_stat       o_stat,
    output logic [30:0]      o_rem
);

    localparam logic [4:0] LAST_STEP = 5'd30;

    logic [30:0] r_dvd;
    logic [30:0] r_div;
    logic [30:0] r_rem;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [31:0] rem_sh;
    logic [31:0] diff;

    always_comb begin
        rem_sh = {r_rem, r_dvd[30]};
        diff   = rem_sh - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= r_busy && (r_cnt == LAST_STEP);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= 31'd0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[29:0], 1'b0};
            // The partial remainder stays below the divisor, so one subtract suffices.
            r_rem <= (rem_sh >= {1'b0, r_div}) ? diff[30:0] : rem_sh[30:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;

endmodule

`default_nettype wire

/* rtl/lcg48_random_generator_top.sv */
// Top level of the 48-bit linear congruential random generator with its sequencer.
//
//  Channel   Direction  Handshake                   Word
//  --------  ---------  --------------------------  ---------------------------------
//  input     in         i_in_valid / o_in_stall     i_op, i_seed_value, i_bit_count,
//                                                   i_bound
//  output    out        o_out_valid / i_out_stall   o_value
//
// One word is worked on at a time; o_in_stall is high from acceptance until the result
// has been placed in the output register. A reseed or a zero bound needs no generator
// step, a single draw or a bounded draw with a power-of-two bound takes one generator
// step, built on the three-pass 16 by 35 bit multiplier, and a long or double draw
// takes two. A bounded draw with a bound that is not a power of two adds the 31-step
// remainder loop, and every rejected draw repeats the generator step and the loop.
// Reset is synchronous and active low; it loads the generator state with the
// multiplier (a seed of zero). A stalled result waits in the output register while
// the next word may already be accepted and worked on.
`default_nettype none

module lcg48_random_generator_top
    import lcg48_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_op,
    input  wire logic [63:0] i_seed_value,
    input  wire logic [5:0]  i_bit_count,
    input  wire logic [30:0] i_bound,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [63:0]      o_value
);

    // Clamp a requested bit count to the range 1 to 32.
    function automatic logic [5:0] clamp_k(input logic [5:0] bc);
        logic [5:0] k;
        if (bc == 6'd0) begin
            k = 6'd1;
        end else if (bc > 6'd32) begin
            k = 6'd32;
        end else begin
            k = bc;
        end
        return k;
    endfunction

    // Number of state bits that the current draw of an operation takes.
    function automatic logic [5:0] k_for(input t_op op, input logic [5:0] kreq,
                                         input logic phase);
        logic [5:0] k;
        unique case (op)
            OP_BITS:    k = kreq;
            OP_BOUNDED: k = 6'd31;
            OP_BOOL:    k = 6'd1;
            OP_FLOAT:   k = 6'd24;
            OP_DOUBLE:  k = phase ? 6'd27 : 6'd26;
            default:    k = 6'd32;
        endcase
        return k;
    endfunction

    // Top k bits of the state, sign-extended from bit 31 (set only for a 32-bit draw).
    function automatic logic [63:0] draw_bits(input logic [47:0] s, input logic [5:0] k);
        logic [5:0]  sh;
        logic [31:0] v;
        sh = 6'd32 - k;
        v  = s[47:16] >> sh[4:0];
        return {{32{v[31]}}, v};
    endfunction

    t_state      r_state, n_state;
    t_op         r_op, n_op;
    logic [5:0]  r_k, n_k;
    logic [30:0] r_bound, n_bound;
    logic        r_pow2, n_pow2;
    logic        r_phase, n_phase;
    logic [47:0] r_lcg, n_lcg;
    logic [31:0] r_hi, n_hi;
    logic [30:0] r_rnd, n_rnd;
    logic [63:0] r_res, n_res;
    logic        r_out_valid, n_out_valid;
    logic [63:0] r_value, n_value;

    logic        mul_start;
    logic        mod_start;
    t_unit_stat  mul_stat;
    t_unit_stat  mod_stat;
    logic [47:0] mul_next;
    logic [30:0] mod_rem;

    logic [5:0]  cur_k;
    logic [63:0] drawn;
    logic [31:0] rej_sum;
    logic [61:0] pow2_prod;
    logic [30:0] in_lowbit;
    logic        out_load;

    lcg48_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_state (r_lcg),
        .o_stat  (mul_stat),
        .o_next  (mul_next)
    );

    lcg48_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (drawn[30:0]),
        .i_divisor  (r_bound),
        .o_stat     (mod_stat),
        .o_rem      (mod_rem)
    );

    always_comb begin
        cur_k     = k_for(r_op, r_k, r_phase);
        drawn     = draw_bits(mul_next, cur_k);
        // A draw is rejected when r - v + (bound - 1) reaches bit 31.
        rej_sum   = {1'b0, r_rnd} - {1'b0, mod_rem} + {1'b0, r_bound} - 32'd1;
        // For a power-of-two bound the product shifted down keeps the top bits of r.
        pow2_prod = {31'b0, r_bound} * {31'b0, r_rnd};
        in_lowbit = i_bound & (~i_bound + 31'd1);
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_k         = r_k;
        n_bound     = r_bound;
        n_pow2      = r_pow2;
        n_phase     = r_phase;
        n_lcg       = r_lcg;
        n_hi        = r_hi;
        n_rnd       = r_rnd;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_value     = r_value;
        mul_start   = 1'b0;
        mod_start   = 1'b0;
        out_load    = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = t_op'(i_op);
                    n_k     = clamp_k(i_bit_count);
                    n_bound = i_bound;
                    n_pow2  = (in_lowbit == i_bound);
                    n_phase = 1'b0;
                    if (t_op'(i_op) == OP_RESEED) begin
                        n_lcg   = i_seed_value[47:0] ^ LCG_MULT;
                        n_res   = 64'd0;
                        n_state = S_DONE;
                    end else if ((t_op'(i_op) == OP_BOUNDED) && (i_bound == 31'd0)) begin
                        // A zero bound gives zero and leaves the state untouched.
                        n_res   = 64'd0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_STEP_GO;
                    end
                end
            end
            S_STEP_GO: begin
                mul_start = 1'b1;
                n_state   = S_STEP_WAIT;
            end
            S_STEP_WAIT: begin
                if (mul_stat.done) begin
                    n_lcg = mul_next;
                    unique case (r_op)
                        OP_LONG: begin
                            if (!r_phase) begin
                                n_hi    = drawn[31:0];
                                n_phase = 1'b1;
                                n_state = S_STEP_GO;
                            end else begin
                                n_res   = {r_hi, 32'b0} + drawn;
                                n_state = S_DONE;
                            end
                        end
                        OP_DOUBLE: begin
                            if (!r_phase) begin
                                n_hi    = drawn[31:0];
                                n_phase = 1'b1;
                                n_state = S_STEP_GO;
                            end else begin
                                n_res   = {11'b0, r_hi[25:0], drawn[26:0]};
                                n_state = S_DONE;
                            end
                        end
                        OP_BOUNDED: begin
                            n_rnd = drawn[30:0];
                            if (r_pow2) begin
                                n_state = S_POW2;
                            end else begin
                                mod_start = 1'b1;
                                n_state   = S_MOD_WAIT;
                            end
                        end
                        default: begin
                            n_res   = drawn;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_MOD_WAIT: begin
                if (mod_stat.done) begin
                    if (rej_sum[31]) begin
                        n_state = S_STEP_GO;
                    end else begin
                        n_res   = {33'b0, mod_rem};
                        n_state = S_DONE;
                    end
                end
            end
            S_POW2: begin
                n_res   = {33'b0, pow2_prod[61:31]};
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load    = 1'b1;
                    n_value     = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_lcg       <= LCG_SEED_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_lcg       <= n_lcg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_k     <= n_k;
        r_bound <= n_bound;
        r_pow2  <= n_pow2;
        r_phase <= n_phase;
        r_hi    <= n_hi;
        r_rnd   <= n_rnd;
        r_res   <= n_res;
        r_value <= n_value;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;

    // An accepted word always holds off the next one by raising o_in_stall.
    a_accept_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after acceptance");

    // The remainder unit is never restarted while it is still iterating.
    a_mod_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_start |-> !mod_stat.busy)
        else $error("remainder unit started while busy");

    // The two units never run at the same time.
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_stat.busy && mod_stat.busy))
        else $error("step and remainder units busy together");

    // Loading a result makes it visible and frees the input side in the next cycle.
    a_load_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_out_valid && !o_in_stall))
        else $error("loaded result not presented");

endmodule

`default_nettype wire
